FILE: sv/tcl_lex_pkg.sv
// Shared types, codes and character classes for the constraint lexer.
// Depends on nothing; every other file refers to it by scoped names.
package tcl_lex_pkg;

  localparam int MAX_NEST = 255;
  localparam int DEPTH_W  = $clog2(MAX_NEST + 1);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [2:0] KIND_EOF     = 3'd0;
  localparam logic [2:0] KIND_STRING  = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_IDENT   = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_SLASH   = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_NUMBER  = 3'd4;
  localparam logic [2:0] MODE_IDENT   = 3'd5;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       first;
    logic       last;
  } out_item_t;

  // One queue entry holds every result of one input item.
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } lex_ent_t;

  typedef struct packed {
    logic full;
    logic nempty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic ident_start(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || c == CH_UNDER || c == CH_MINUS;
  endfunction

  function automatic logic ident_more(input logic [7:0] c);
    return ident_start(c) || is_digit(c) || c == CH_SLASH || c == CH_LBRACK ||
           c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  function automatic logic number_more(input logic [7:0] c);
    return is_digit(c) || c == CH_DOT || c == CH_LOW_E || c == CH_UP_E ||
           c == CH_PLUS || c == CH_MINUS;
  endfunction

endpackage

FILE: sv/tcl_constraint_lexer.sv
// Streaming lexer for constraint text, one byte (or an end mark) per item.
// It takes one item every cycle while its four-entry result queue has room.
// Results leave at one per cycle while the reader pops; an item after a held
// slash can give two results, so it holds the output side for both and the
// queue absorbs the difference. Accepted results go to the queue, then to the
// back end's output register. Depends on tcl_lex_pkg and the tcl_lex_* parts.
module tcl_constraint_lexer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  tcl_lex_pkg::in_item_t  in_item,
  output logic                   empty,
  input  logic                   pop,
  output tcl_lex_pkg::out_item_t out_item
);

  logic                  acc, ent_push, q_pop;
  tcl_lex_pkg::lex_ent_t ent, q_data;
  tcl_lex_pkg::q_stat_t  q_stat;

  assign full = q_stat.full;
  assign acc  = push && !q_stat.full;

  tcl_lex_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_item  (in_item),
    .ent_push (ent_push),
    .ent      (ent)
  );

  tcl_lex_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ent_push),
    .wdata (ent),
    .pop   (q_pop),
    .rdata (q_data),
    .stat  (q_stat)
  );

  tcl_lex_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (q_stat),
    .rdata    (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

FILE: sv/tcl_lex_front.sv
// Lexer front end: holds the token state and turns each accepted item that
// yields results into one queue entry of up to two. Depends on tcl_lex_pkg.
module tcl_lex_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  tcl_lex_pkg::in_item_t in_item,
  output logic                 ent_push,
  output tcl_lex_pkg::lex_ent_t ent
);

  logic [2:0]                     mode_r, mode_nxt;
  logic                           brace_r, brace_nxt;
  logic [tcl_lex_pkg::DEPTH_W-1:0] depth_r, depth_nxt;

  localparam logic [tcl_lex_pkg::DEPTH_W-1:0] NEST_LIM =
    tcl_lex_pkg::DEPTH_W'(tcl_lex_pkg::MAX_NEST);
  localparam logic [tcl_lex_pkg::DEPTH_W-1:0] ONE = tcl_lex_pkg::DEPTH_W'(1);

  logic [7:0] c;
  logic       do_begin, pre, main_v;
  logic [2:0] main_kind;
  logic       main_first;
  logic [7:0] main_byte;
  logic       b_emit;
  logic [2:0] b_kind, b_mode;
  logic       b_str;
  logic       opener, closer;
  tcl_lex_pkg::out_item_t slash_res, main_res;

  assign c = in_item.ch;

  // What starting a token on this byte would do.
  always_comb begin
    b_emit = 1'b0;
    b_kind = tcl_lex_pkg::KIND_UNKNOWN;
    b_mode = tcl_lex_pkg::MODE_IDLE;
    b_str  = 1'b0;
    if (tcl_lex_pkg::is_space(c)) begin
      b_mode = tcl_lex_pkg::MODE_IDLE;
    end else if (c == tcl_lex_pkg::CH_HASH) begin
      b_mode = tcl_lex_pkg::MODE_COMMENT;
    end else if (c == tcl_lex_pkg::CH_SLASH) begin
      b_mode = tcl_lex_pkg::MODE_SLASH;
    end else if (c == tcl_lex_pkg::CH_LBRACE || c == tcl_lex_pkg::CH_LBRACK) begin
      b_mode = tcl_lex_pkg::MODE_STRING;
      b_kind = tcl_lex_pkg::KIND_STRING;
      b_emit = 1'b1;
      b_str  = 1'b1;
    end else if (tcl_lex_pkg::is_digit(c) || c == tcl_lex_pkg::CH_DOT) begin
      b_mode = tcl_lex_pkg::MODE_NUMBER;
      b_kind = tcl_lex_pkg::KIND_NUMBER;
      b_emit = 1'b1;
    end else if (tcl_lex_pkg::ident_start(c)) begin
      b_mode = tcl_lex_pkg::MODE_IDENT;
      b_kind = tcl_lex_pkg::KIND_IDENT;
      b_emit = 1'b1;
    end else begin
      b_emit = 1'b1;
    end
  end

  assign opener = brace_r ? (c == tcl_lex_pkg::CH_LBRACE) : (c == tcl_lex_pkg::CH_LBRACK);
  assign closer = brace_r ? (c == tcl_lex_pkg::CH_RBRACE) : (c == tcl_lex_pkg::CH_RBRACK);

  always_comb begin
    mode_nxt   = mode_r;
    brace_nxt  = brace_r;
    depth_nxt  = depth_r;
    do_begin   = 1'b0;
    pre        = 1'b0;
    main_v     = 1'b0;
    main_kind  = tcl_lex_pkg::KIND_EOF;
    main_byte  = c;
    main_first = 1'b0;
    if (in_item.end_mark) begin
      pre        = (mode_r == tcl_lex_pkg::MODE_SLASH);
      main_v     = 1'b1;
      main_kind  = tcl_lex_pkg::KIND_EOF;
      main_byte  = 8'd0;
      main_first = 1'b1;
      mode_nxt   = tcl_lex_pkg::MODE_IDLE;
      brace_nxt  = 1'b0;
      depth_nxt  = '0;
    end else begin
      case (mode_r)
        tcl_lex_pkg::MODE_COMMENT: begin
          if (c == tcl_lex_pkg::CH_NL) mode_nxt = tcl_lex_pkg::MODE_IDLE;
        end
        tcl_lex_pkg::MODE_SLASH: begin
          if (c == tcl_lex_pkg::CH_SLASH) begin
            mode_nxt = tcl_lex_pkg::MODE_COMMENT;
          end else begin
            pre      = 1'b1;
            do_begin = 1'b1;
          end
        end
        tcl_lex_pkg::MODE_STRING: begin
          main_v    = 1'b1;
          main_kind = tcl_lex_pkg::KIND_STRING;
          if (opener) begin
            if (depth_r < NEST_LIM) depth_nxt = depth_r + ONE;
          end else if (closer) begin
            if (depth_r <= ONE) begin
              depth_nxt = '0;
              mode_nxt  = tcl_lex_pkg::MODE_IDLE;
            end else begin
              depth_nxt = depth_r - ONE;
            end
          end
        end
        tcl_lex_pkg::MODE_NUMBER: begin
          if (tcl_lex_pkg::number_more(c)) begin
            main_v    = 1'b1;
            main_kind = tcl_lex_pkg::KIND_NUMBER;
          end else begin
            do_begin = 1'b1;
          end
        end
        tcl_lex_pkg::MODE_IDENT: begin
          if (tcl_lex_pkg::ident_more(c)) begin
            main_v    = 1'b1;
            main_kind = tcl_lex_pkg::KIND_IDENT;
          end else begin
            do_begin = 1'b1;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase
      if (do_begin) begin
        mode_nxt   = b_mode;
        main_v     = b_emit;
        main_kind  = b_kind;
        main_first = 1'b1;
        if (b_str) begin
          brace_nxt = (c == tcl_lex_pkg::CH_LBRACE);
          depth_nxt = ONE;
        end
      end
    end
  end

  always_comb begin
    slash_res.kind     = tcl_lex_pkg::KIND_UNKNOWN;
    slash_res.out_byte = tcl_lex_pkg::CH_SLASH;
    slash_res.first    = 1'b1;
    slash_res.last     = !main_v;
    main_res.kind      = main_kind;
    main_res.out_byte  = main_byte;
    main_res.first     = main_first;
    main_res.last      = 1'b1;
    ent.two = pre && main_v;
    ent.r0  = pre ? slash_res : main_res;
    ent.r1  = main_res;
  end

  assign ent_push = acc && (pre || main_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tcl_lex_pkg::MODE_IDLE;
      brace_r <= 1'b0;
      depth_r <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      brace_r <= brace_nxt;
      depth_r <= depth_nxt;
    end
  end

endmodule

FILE: sv/tcl_lex_fifo.sv
// Short queue of result entries between the lexer front and back ends.
// Depends on tcl_lex_pkg for the entry type and depth.
module tcl_lex_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tcl_lex_pkg::lex_ent_t wdata,
  input  logic                  pop,
  output tcl_lex_pkg::lex_ent_t rdata,
  output tcl_lex_pkg::q_stat_t  stat
);

  localparam int CNT_W = $clog2(tcl_lex_pkg::QDEPTH + 1);

  tcl_lex_pkg::lex_ent_t mem [tcl_lex_pkg::QDEPTH];
  logic [tcl_lex_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;

  assign stat.full   = (cnt_r == CNT_W'(tcl_lex_pkg::QDEPTH));
  assign stat.nempty = (cnt_r != '0);
  assign rdata       = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

FILE: sv/tcl_lex_back.sv
// Lexer back end: takes queue entries and hands out their results one at a
// time from a held register. Depends on tcl_lex_pkg.
module tcl_lex_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcl_lex_pkg::q_stat_t   stat,
  input  tcl_lex_pkg::lex_ent_t  rdata,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output tcl_lex_pkg::out_item_t out_item
);

  logic                  vld_r, vld_nxt;
  logic                  sel_r, sel_nxt;
  tcl_lex_pkg::lex_ent_t ent_r;
  logic                  taken, done;

  assign empty    = !vld_r;
  assign out_item = sel_r ? ent_r.r1 : ent_r.r0;
  assign taken    = pop && vld_r;
  // The held entry is used up once its final result is taken.
  assign done     = taken && (!ent_r.two || sel_r);
  assign q_pop    = stat.nempty && (!vld_r || done);

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (q_pop) begin
      vld_nxt = 1'b1;
      sel_nxt = 1'b0;
    end else if (done) begin
      vld_nxt = 1'b0;
      sel_nxt = 1'b0;
    end else if (taken) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) ent_r <= rdata;
  end

endmodule

FILE: sv/tcl_lex_chk.sv
// Port-level checks for the constraint lexer, bound to the top level.
// Depends on tcl_lex_pkg for item types and token codes.
module tcl_lex_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   push,
  input logic                   full,
  input tcl_lex_pkg::in_item_t  in_item,
  input logic                   empty,
  input logic                   pop,
  input tcl_lex_pkg::out_item_t out_item
);

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before it was taken");

  // An end-of-file result always has a zero byte and both first and last set.
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.kind == tcl_lex_pkg::KIND_EOF) |->
    (out_item.out_byte == 8'd0 && out_item.first && out_item.last))
    else $error("malformed end-of-file result");

  // Only a flushed slash is ever followed by a second result of the same item.
  a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.last) |->
    (out_item.kind == tcl_lex_pkg::KIND_UNKNOWN &&
     out_item.out_byte == tcl_lex_pkg::CH_SLASH && out_item.first))
    else $error("unexpected non-final result");

endmodule

bind tcl_constraint_lexer tcl_lex_chk u_chk (.*);

FILE: verif/lexer_checker.sv
// Checker for the constraint lexer. It predicts the results of every accepted
// item and compares each popped result with the oldest prediction.
// Depends on tcl_lex_pkg for the item types and the kind, mode and character codes.
module lexer_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic                   full,
  input  tcl_lex_pkg::in_item_t  in_item,
  input  logic                   empty,
  input  logic                   pop,
  input  tcl_lex_pkg::out_item_t out_item,
  output int                     fail_count,
  output int                     tokens_due
);

  logic [2:0]                      lex_mode = tcl_lex_pkg::MODE_IDLE;
  logic                            brace_open = 1'b0;
  logic [tcl_lex_pkg::DEPTH_W-1:0] nest = '0;
  tcl_lex_pkg::out_item_t          due_q[$];
  tcl_lex_pkg::out_item_t          step_res[$];
  int                              mismatches = 0;

  function automatic logic blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic decimal(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic word_head(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           c == tcl_lex_pkg::CH_UNDER || c == tcl_lex_pkg::CH_MINUS;
  endfunction

  function automatic logic word_tail(input logic [7:0] c);
    return word_head(c) || decimal(c) || c == tcl_lex_pkg::CH_SLASH ||
           c == tcl_lex_pkg::CH_LBRACK || c == tcl_lex_pkg::CH_RBRACK ||
           c == tcl_lex_pkg::CH_LBRACE || c == tcl_lex_pkg::CH_RBRACE;
  endfunction

  function automatic logic num_tail(input logic [7:0] c);
    return decimal(c) || c == tcl_lex_pkg::CH_DOT || c == tcl_lex_pkg::CH_LOW_E ||
           c == tcl_lex_pkg::CH_UP_E || c == tcl_lex_pkg::CH_PLUS ||
           c == tcl_lex_pkg::CH_MINUS;
  endfunction

  function automatic void emit(input logic [2:0] k, input logic [7:0] b, input logic f);
    tcl_lex_pkg::out_item_t r;
    r.kind = k;
    r.out_byte = b;
    r.first = f;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  // A byte seen between tokens, or the byte that ended the previous token.
  function automatic void start_token(input logic [7:0] c);
    lex_mode = tcl_lex_pkg::MODE_IDLE;
    if (blank(c)) begin
    end else if (c == tcl_lex_pkg::CH_HASH) begin
      lex_mode = tcl_lex_pkg::MODE_COMMENT;
    end else if (c == tcl_lex_pkg::CH_SLASH) begin
      lex_mode = tcl_lex_pkg::MODE_SLASH;
    end else if (c == tcl_lex_pkg::CH_LBRACE || c == tcl_lex_pkg::CH_LBRACK) begin
      lex_mode = tcl_lex_pkg::MODE_STRING;
      brace_open = (c == tcl_lex_pkg::CH_LBRACE);
      nest = tcl_lex_pkg::DEPTH_W'(1);
      emit(tcl_lex_pkg::KIND_STRING, c, 1'b1);
    end else if (decimal(c) || c == tcl_lex_pkg::CH_DOT) begin
      lex_mode = tcl_lex_pkg::MODE_NUMBER;
      emit(tcl_lex_pkg::KIND_NUMBER, c, 1'b1);
    end else if (word_head(c)) begin
      lex_mode = tcl_lex_pkg::MODE_IDENT;
      emit(tcl_lex_pkg::KIND_IDENT, c, 1'b1);
    end else begin
      emit(tcl_lex_pkg::KIND_UNKNOWN, c, 1'b1);
    end
  endfunction

  function automatic void lex_item(input tcl_lex_pkg::in_item_t it);
    logic [7:0]             c;
    logic [7:0]             opener;
    logic [7:0]             closer;
    tcl_lex_pkg::out_item_t r;
    c = it.ch;
    step_res.delete();
    if (it.end_mark) begin
      if (lex_mode == tcl_lex_pkg::MODE_SLASH)
        emit(tcl_lex_pkg::KIND_UNKNOWN, tcl_lex_pkg::CH_SLASH, 1'b1);
      emit(tcl_lex_pkg::KIND_EOF, 8'h00, 1'b1);
      lex_mode = tcl_lex_pkg::MODE_IDLE;
      brace_open = 1'b0;
      nest = '0;
    end else begin
      case (lex_mode)
        tcl_lex_pkg::MODE_COMMENT: if (c == tcl_lex_pkg::CH_NL) lex_mode = tcl_lex_pkg::MODE_IDLE;
        tcl_lex_pkg::MODE_SLASH: begin
          if (c == tcl_lex_pkg::CH_SLASH) begin
            lex_mode = tcl_lex_pkg::MODE_COMMENT;
          end else begin
            emit(tcl_lex_pkg::KIND_UNKNOWN, tcl_lex_pkg::CH_SLASH, 1'b1);
            start_token(c);
          end
        end
        tcl_lex_pkg::MODE_STRING: begin
          opener = brace_open ? tcl_lex_pkg::CH_LBRACE : tcl_lex_pkg::CH_LBRACK;
          closer = brace_open ? tcl_lex_pkg::CH_RBRACE : tcl_lex_pkg::CH_RBRACK;
          emit(tcl_lex_pkg::KIND_STRING, c, 1'b0);
          // Only the bracket type that opened the string counts toward nesting.
          if (c == opener) begin
            if (nest < tcl_lex_pkg::MAX_NEST) nest = nest + 1'b1;
          end else if (c == closer) begin
            if (nest <= 1) begin
              nest = '0;
              lex_mode = tcl_lex_pkg::MODE_IDLE;
            end else begin
              nest = nest - 1'b1;
            end
          end
        end
        tcl_lex_pkg::MODE_NUMBER: begin
          if (num_tail(c)) emit(tcl_lex_pkg::KIND_NUMBER, c, 1'b0);
          else start_token(c);
        end
        tcl_lex_pkg::MODE_IDENT: begin
          if (word_tail(c)) emit(tcl_lex_pkg::KIND_IDENT, c, 1'b0);
          else start_token(c);
        end
        default: start_token(c);
      endcase
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      due_q.push_back(r);
    end
  endfunction

  task automatic report(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    tcl_lex_pkg::out_item_t want;
    if (!rst_n) begin
      lex_mode = tcl_lex_pkg::MODE_IDLE;
      brace_open = 1'b0;
      nest = '0;
      due_q.delete();
    end else begin
      // No result can leave in the cycle its item enters, so check before predicting.
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d byte %02h",
                           out_item.kind, out_item.out_byte));
        end else begin
          want = due_q.pop_front();
          if (out_item.kind !== want.kind || out_item.out_byte !== want.out_byte ||
              out_item.first !== want.first || out_item.last !== want.last)
            report($sformatf("kind %0d/%0d byte %02h/%02h first %b/%b last %b/%b (got/exp)",
                             out_item.kind, want.kind, out_item.out_byte, want.out_byte,
                             out_item.first, want.first, out_item.last, want.last));
        end
      end
      if (push && !full) lex_item(in_item);
    end
    fail_count <= mismatches;
    tokens_due <= due_q.size();
  end

endmodule

FILE: verif/testbench.sv
// Top of the lexer test: clock, reset, byte stream stimulus with random gaps on
// both sides, and the verdict. Depends on tcl_lex_pkg, lexer_checker and the lexer RTL.
module testbench;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   pop = 1'b0;
  tcl_lex_pkg::in_item_t  in_item = '0;
  logic                   full;
  logic                   empty;
  tcl_lex_pkg::out_item_t out_item;
  int                     fail_count;
  int                     tokens_due;
  logic                   steady = 1'b0;
  int                     token_items = 0;

  tcl_constraint_lexer dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  lexer_checker watcher (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .fail_count(fail_count), .tokens_due(tokens_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    pop <= steady || ($urandom_range(99) >= 15);
  end

  initial begin
    #600000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic em = 1'b0);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= '{ch: c, end_mark: em};
    @(posedge clk);
    while (full) @(posedge clk);
    token_items++;
  endtask

  task automatic put_str(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (tokens_due != 0) @(posedge clk);
  endtask

  // A braced or bracketed string with random nesting; now and then it is left open.
  task automatic send_string_token();
    logic       brace;
    logic [7:0] op;
    logic [7:0] cl;
    logic [7:0] b;
    int         d;
    brace = 1'($urandom_range(1));
    op = brace ? tcl_lex_pkg::CH_LBRACE : tcl_lex_pkg::CH_LBRACK;
    cl = brace ? tcl_lex_pkg::CH_RBRACE : tcl_lex_pkg::CH_RBRACK;
    d = 1;
    send_byte(op);
    repeat ($urandom_range(10)) begin
      case ($urandom_range(4))
        0: begin
          send_byte(op);
          d++;
        end
        1: begin
          if (d > 1) begin
            send_byte(cl);
            d--;
          end
        end
        default: begin
          b = 8'($urandom_range(126, 32));
          if (b == op || b == cl) b = 8'h61;
          send_byte(b);
        end
      endcase
    end
    if ($urandom_range(9) != 0) repeat (d) send_byte(cl);
  endtask

  initial begin
    logic [7:0] b;
    logic       paused = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hff);
    put_str("_a9/ ");
    put_str(".5e-x");
    put_str(" /q");
    put_str("#c\n");
    put_str("//\n");
    put_str("{[}");
    send_byte(tcl_lex_pkg::CH_SLASH);
    send_byte(8'hff, 1'b1);
    put_str("{a");
    send_byte(8'h00, 1'b1);
    wait_drained();

    // Drive the nesting count past its ceiling, close the string, then one stray closer.
    send_byte(tcl_lex_pkg::CH_LBRACE);
    repeat (tcl_lex_pkg::MAX_NEST + 5) send_byte(tcl_lex_pkg::CH_LBRACE);
    repeat (tcl_lex_pkg::MAX_NEST) send_byte(tcl_lex_pkg::CH_RBRACE);
    send_byte(tcl_lex_pkg::CH_RBRACE);

    while (token_items < 750) begin
      steady = (token_items >= 580 && token_items < 660);
      if (!paused && token_items >= 690) begin
        wait_drained();
        paused = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:21]: begin
          send_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_-"));
          repeat ($urandom_range(7))
            send_byte(pick("azAZqQ_-0123456789/[]{}"));
        end
        [22:37]: begin
          send_byte(pick(".0123456789"));
          repeat ($urandom_range(6)) send_byte(pick("0123456789.eE+-"));
        end
        [38:51]: send_string_token();
        [52:59]: begin
          if ($urandom_range(1)) begin
            send_byte(tcl_lex_pkg::CH_HASH);
          end else begin
            send_byte(tcl_lex_pkg::CH_SLASH);
            send_byte(tcl_lex_pkg::CH_SLASH);
          end
          repeat ($urandom_range(6)) begin
            b = 8'($urandom_range(255));
            if (b == tcl_lex_pkg::CH_NL) b = 8'h0b;
            send_byte(b);
          end
          send_byte(tcl_lex_pkg::CH_NL);
        end
        [60:74]: begin
          repeat ($urandom_range(3, 1)) begin
            b = 8'($urandom_range(13, 8));
            if (b == 8'd8) b = 8'd32;
            send_byte(b);
          end
        end
        [75:81]: begin
          send_byte(tcl_lex_pkg::CH_SLASH);
          send_byte(8'($urandom_range(255)));
        end
        [82:93]: send_byte(8'($urandom_range(255)));
        default: send_byte(8'($urandom_range(255)), 1'b1);
      endcase
    end

    steady = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && tokens_due == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tcl_lex_pkg.sv
sv/tcl_lex_front.sv
sv/tcl_lex_fifo.sv
sv/tcl_lex_back.sv
sv/tcl_constraint_lexer.sv
sv/tcl_lex_chk.sv
verif/lexer_checker.sv
verif/testbench.sv
